@@ design/dgpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dgpc_pkg
// Shared types, codes and helpers for the downhill grid path counter.
// ----------------------------------------------------------------------------
package dgpc_pkg;

    // walk sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INIT,
        ST_FETCH,
        ST_QWAIT,
        ST_CWAIT,
        ST_NSEL,
        ST_NEVAL,
        ST_FIN,
        ST_FWAIT
    } t_state;

    // neighbor step order: right, down, left, up
    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    // configuration register indexes
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam int COUNT_W  = 32;
    localparam int HEIGHT_W = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int CFG_W    = 7;

    // walker status seen by the top level
    typedef struct packed {
        logic idle;
        logic clearing;
    } t_walk_status;

    // saturating add: MSB is the saturation flag
    function automatic logic [COUNT_W:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COUNT_W]) begin
            return {1'b1, {COUNT_W{1'b1}}};
        end
        return s;
    endfunction

endpackage

@@ design/dgpc_if.sv @@
// ----------------------------------------------------------------------------
// dgpc_in_if / dgpc_out_if
// Valid/ready channels for height beats and result beats.
// ----------------------------------------------------------------------------
interface dgpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] height;
    logic        last_cell;
    modport source (output valid, height, last_cell, input ready);
    modport sink   (input valid, height, last_cell, output ready);
endinterface

interface dgpc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] path_count;
    logic        overflow;
    modport source (output valid, path_count, overflow, input ready);
    modport sink   (input valid, path_count, overflow, output ready);
endinterface

@@ design/dgpc_ram.sv @@
// ----------------------------------------------------------------------------
// dgpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dgpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dgpc_cfg.sv @@
// ----------------------------------------------------------------------------
// dgpc_cfg
// APB register file for row and column counts, clamped on write.
// ----------------------------------------------------------------------------
module dgpc_cfg #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [dgpc_pkg::PADDR_W-1:0]            paddr,
    input  logic [dgpc_pkg::PDATA_W-1:0]            pwdata,
    output logic [dgpc_pkg::PDATA_W-1:0]            prdata,
    output logic                                    pready,
    output logic [$clog2(MAX_ROWS+1)-1:0]           o_rows,
    output logic [$clog2(MAX_COLUMNS+1)-1:0]        o_cols
);

    localparam int RW       = $clog2(MAX_ROWS + 1);
    localparam int CLW      = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int COLS_RST = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;

    logic [RW-1:0]  r_rows, n_rows;
    logic [CLW-1:0] r_cols, n_cols;
    logic           w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // clamp 0 to 1 and large values to the maximum
    always_comb begin
        int v;
        v      = int'(pwdata[dgpc_pkg::CFG_W-1:0]);
        n_rows = r_rows;
        n_cols = r_cols;
        if (w_wr && (paddr[2] == dgpc_pkg::REG_ROW_COUNT)) begin
            n_rows = (v == 0) ? RW'(1) : ((v > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(v));
        end
        if (w_wr && (paddr[2] == dgpc_pkg::REG_COLUMN_COUNT)) begin
            n_cols = (v == 0) ? CLW'(1) :
                     ((v > MAX_COLUMNS) ? CLW'(MAX_COLUMNS) : CLW'(v));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RW'(ROWS_RST);
            r_cols <= CLW'(COLS_RST);
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
        end
    end

    // read back
    assign prdata = (paddr[2] == dgpc_pkg::REG_ROW_COUNT) ?
                    dgpc_pkg::PDATA_W'(r_rows) : dgpc_pkg::PDATA_W'(r_cols);

    assign o_rows = r_rows;
    assign o_cols = r_cols;

endmodule

@@ design/dgpc_walk.sv @@
// ----------------------------------------------------------------------------
// dgpc_walk
// Height loader and frontier walk sequencer around three saturating adders.
// ----------------------------------------------------------------------------
module dgpc_walk #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     i_rows,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]  i_cols,
    dgpc_in_if.sink                           i_in,
    dgpc_out_if.source                        o_out,
    output dgpc_pkg::t_walk_status            o_status
);

    localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNW   = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CLW   = $clog2(MAX_COLUMNS + 1);
    localparam int QD    = 2 * CELLS;
    localparam int QAW   = $clog2(QD);
    localparam int OW    = $clog2(QD + 1);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int CW    = dgpc_pkg::COUNT_W;
    localparam int HW    = dgpc_pkg::HEIGHT_W;
    localparam int EW    = AW + RW + CLW;
    localparam int SW    = LW + 2 * CW;

    dgpc_pkg::t_state r_state, n_state;
    dgpc_pkg::t_dir   r_dir, n_dir;

    logic [CNW-1:0] r_lpos, n_lpos;
    logic [AW-1:0]  r_clr, n_clr;
    logic [QAW-1:0] r_hp, n_hp;
    logic [OW-1:0]  r_occ, n_occ;
    logic [EW-1:0]  r_ent, n_ent;
    logic [HW-1:0]  r_hc, n_hc;
    logic [LW-1:0]  r_lc, n_lc;
    logic [CW-1:0]  r_cc, n_cc;
    logic [EW-1:0]  r_nb, n_nb;
    logic           r_sat, n_sat;
    logic           r_oval, n_oval;
    logic [CW-1:0]  r_ocnt, n_ocnt;
    logic           r_oovf, n_oovf;

    // memory ports
    logic           h_we, s_we, q_we;
    logic [AW-1:0]  h_waddr, h_raddr, s_waddr, s_raddr;
    logic [HW-1:0]  h_rdata;
    logic [SW-1:0]  s_wdata, s_rdata;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [EW-1:0]  q_wdata, q_rdata;

    logic [CNW-1:0] w_cells;
    logic [AW-1:0]  w_last;
    logic           w_acc, w_ofree;
    logic [QAW-1:0] w_tail, w_hp_inc;
    logic           w_inb;
    logic [EW-1:0]  w_nbent;

    // cell entry fields
    logic [AW-1:0]  e_idx;
    logic [RW-1:0]  e_row;
    logic [CLW-1:0] e_col;
    // neighbor state fields
    logic [CW-1:0]  nb_e, nb_c;
    logic [LW-1:0]  nb_l;
    logic [CW:0]    w_add_c, w_add_e, w_add_f;

    assign w_cells = CNW'(32'(i_rows) * 32'(i_cols));
    assign w_last  = AW'(w_cells - CNW'(1));
    assign w_acc   = i_in.valid && i_in.ready;
    assign w_ofree = !r_oval || o_out.ready;

    assign {e_idx, e_row, e_col} = r_ent;
    assign {nb_e, nb_c, nb_l}    = s_rdata;

    // queue tail and head wrap
    always_comb begin
        logic [OW:0] t;
        t        = (OW+1)'(r_hp) + (OW+1)'(r_occ);
        if (t >= (OW+1)'(QD)) begin
            t = t - (OW+1)'(QD);
        end
        w_tail   = QAW'(t);
        w_hp_inc = (r_hp == QAW'(QD - 1)) ? '0 : r_hp + QAW'(1);
    end

    // neighbor of the current cell in direction r_dir
    always_comb begin
        w_inb   = 1'b0;
        w_nbent = '0;
        unique case (r_dir)
            dgpc_pkg::DIR_RIGHT: begin
                w_inb   = (CLW+1)'(e_col) + (CLW+1)'(1) < (CLW+1)'(i_cols);
                w_nbent = {AW'(e_idx + AW'(1)), e_row, CLW'(e_col + CLW'(1))};
            end
            dgpc_pkg::DIR_DOWN: begin
                w_inb   = (RW+1)'(e_row) + (RW+1)'(1) < (RW+1)'(i_rows);
                w_nbent = {AW'((CNW+1)'(e_idx) + (CNW+1)'(i_cols)),
                           RW'(e_row + RW'(1)), e_col};
            end
            dgpc_pkg::DIR_LEFT: begin
                w_inb   = e_col != '0;
                w_nbent = {AW'(e_idx - AW'(1)), e_row, CLW'(e_col - CLW'(1))};
            end
            dgpc_pkg::DIR_UP: begin
                w_inb   = e_row != '0;
                w_nbent = {AW'((CNW+1)'(e_idx) - (CNW+1)'(i_cols)),
                           RW'(e_row - RW'(1)), e_col};
            end
            default: begin
                w_inb   = 1'b0;
                w_nbent = '0;
            end
        endcase
    end

    // saturating adders
    assign w_add_c = dgpc_pkg::sat_add(nb_c, r_cc);
    assign w_add_e = dgpc_pkg::sat_add(nb_e, nb_c);
    assign w_add_f = dgpc_pkg::sat_add(nb_e, nb_c);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dgpc_pkg::ST_IDLE:  if (w_acc && i_in.last_cell) n_state = dgpc_pkg::ST_CLEAR;
            dgpc_pkg::ST_CLEAR: if (r_clr == w_last) n_state = dgpc_pkg::ST_INIT;
            dgpc_pkg::ST_INIT:  n_state = dgpc_pkg::ST_FETCH;
            dgpc_pkg::ST_FETCH: begin
                n_state = (r_occ == '0) ? dgpc_pkg::ST_FIN : dgpc_pkg::ST_QWAIT;
            end
            dgpc_pkg::ST_QWAIT: n_state = dgpc_pkg::ST_CWAIT;
            dgpc_pkg::ST_CWAIT: n_state = dgpc_pkg::ST_NSEL;
            dgpc_pkg::ST_NSEL: begin
                if (w_inb) begin
                    n_state = dgpc_pkg::ST_NEVAL;
                end else if (r_dir == dgpc_pkg::DIR_UP) begin
                    n_state = dgpc_pkg::ST_FETCH;
                end
            end
            dgpc_pkg::ST_NEVAL: begin
                n_state = (r_dir == dgpc_pkg::DIR_UP) ? dgpc_pkg::ST_FETCH :
                                                        dgpc_pkg::ST_NSEL;
            end
            dgpc_pkg::ST_FIN:   n_state = dgpc_pkg::ST_FWAIT;
            dgpc_pkg::ST_FWAIT: if (w_ofree) n_state = dgpc_pkg::ST_IDLE;
            default:            n_state = dgpc_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        logic push, pop;
        push    = 1'b0;
        pop     = 1'b0;
        n_dir   = r_dir;
        n_lpos  = r_lpos;
        n_clr   = r_clr;
        n_hp    = r_hp;
        n_occ   = r_occ;
        n_ent   = r_ent;
        n_hc    = r_hc;
        n_lc    = r_lc;
        n_cc    = r_cc;
        n_nb    = r_nb;
        n_sat   = r_sat;
        n_oval  = r_oval && !o_out.ready;
        n_ocnt  = r_ocnt;
        n_oovf  = r_oovf;
        h_we    = 1'b0;
        h_waddr = AW'(r_lpos);
        h_raddr = e_idx;
        s_we    = 1'b0;
        s_waddr = r_clr;
        s_wdata = '0;
        s_raddr = w_last;
        q_we    = 1'b0;
        q_waddr = w_tail;
        q_wdata = r_nb;
        q_raddr = r_hp;
        unique case (r_state)
            dgpc_pkg::ST_IDLE: begin
                // load heights until the grid is full
                if (w_acc) begin
                    if (r_lpos < w_cells) begin
                        h_we   = 1'b1;
                        n_lpos = r_lpos + CNW'(1);
                    end
                    if (i_in.last_cell) begin
                        n_lpos = '0;
                        n_clr  = '0;
                    end
                end
            end
            dgpc_pkg::ST_CLEAR: begin
                s_we  = 1'b1;
                n_clr = r_clr + AW'(1);
            end
            dgpc_pkg::ST_INIT: begin
                // seed the top-left cell
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = {CW'(0), CW'(1), LW'(0)};
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '0;
                n_hp    = '0;
                n_occ   = OW'(1);
                n_sat   = 1'b0;
            end
            dgpc_pkg::ST_QWAIT: begin
                n_ent   = q_rdata;
                h_raddr = q_rdata[EW-1 -: AW];
                s_raddr = q_rdata[EW-1 -: AW];
            end
            dgpc_pkg::ST_CWAIT: begin
                n_hc  = h_rdata;
                n_lc  = nb_l;
                n_cc  = nb_c;
                n_dir = dgpc_pkg::DIR_RIGHT;
            end
            dgpc_pkg::ST_NSEL: begin
                h_raddr = w_nbent[EW-1 -: AW];
                s_raddr = w_nbent[EW-1 -: AW];
                n_nb    = w_nbent;
                if (!w_inb) begin
                    if (r_dir == dgpc_pkg::DIR_UP) begin
                        pop = 1'b1;
                    end else begin
                        n_dir = dgpc_pkg::t_dir'(r_dir + 2'd1);
                    end
                end
            end
            dgpc_pkg::ST_NEVAL: begin
                s_waddr = r_nb[EW-1 -: AW];
                if (r_hc > h_rdata) begin
                    s_we = 1'b1;
                    if ((LW+1)'(nb_l) == (LW+1)'(r_lc) + (LW+1)'(1)) begin
                        s_wdata = {nb_e, w_add_c[CW-1:0], nb_l};
                        n_sat   = r_sat | w_add_c[CW];
                    end else begin
                        s_wdata = {w_add_e[CW-1:0], r_cc, LW'(r_lc + LW'(1))};
                        n_sat   = r_sat | w_add_e[CW];
                        push    = r_occ < OW'(QD);
                    end
                end
                q_we = push;
                if (r_dir == dgpc_pkg::DIR_UP) begin
                    pop = 1'b1;
                end else begin
                    n_dir = dgpc_pkg::t_dir'(r_dir + 2'd1);
                end
            end
            dgpc_pkg::ST_FWAIT: begin
                if (w_ofree) begin
                    n_oval = 1'b1;
                    n_ocnt = w_add_f[CW-1:0];
                    n_oovf = r_sat | w_add_f[CW];
                end
            end
            default: begin
            end
        endcase
        if (pop) begin
            n_hp = w_hp_inc;
        end
        n_occ = (r_state == dgpc_pkg::ST_INIT) ? n_occ :
                OW'(r_occ + OW'(push) - OW'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgpc_pkg::ST_IDLE;
            r_lpos  <= '0;
            r_occ   <= '0;
            r_oval  <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lpos  <= n_lpos;
            r_occ   <= n_occ;
            r_oval  <= n_oval;
            r_sat   <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir  <= n_dir;
        r_clr  <= n_clr;
        r_hp   <= n_hp;
        r_ent  <= n_ent;
        r_hc   <= n_hc;
        r_lc   <= n_lc;
        r_cc   <= n_cc;
        r_nb   <= n_nb;
        r_ocnt <= n_ocnt;
        r_oovf <= n_oovf;
    end

    // height store
    dgpc_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_height (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (i_in.height),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // per-cell level, current count and earlier count
    dgpc_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_cell (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // frontier ring
    dgpc_ram #(.WIDTH(EW), .DEPTH(QD)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign i_in.ready       = (r_state == dgpc_pkg::ST_IDLE);
    assign o_out.valid      = r_oval;
    assign o_out.path_count = r_ocnt;
    assign o_out.overflow   = r_oovf;

    assign o_status.idle     = (r_state == dgpc_pkg::ST_IDLE);
    assign o_status.clearing = (r_state == dgpc_pkg::ST_CLEAR);

endmodule

@@ design/downhill_grid_path_counter_core.sv @@
// ----------------------------------------------------------------------------
// downhill_grid_path_counter_core
// Counts strictly downhill 4-neighbor paths from top-left to bottom-right.
//
//   channel   dir   handshake         beat contents
//   i_in      in    valid/ready       height, last_cell
//   o_out     out   valid/ready       path_count, overflow
//   apb       in    psel/penable      row_count @0x0, column_count @0x4
//
// Height beats are loaded while the core is idle. A beat with last_cell starts
// a run: a clearing pass over the rows*cols entries of the cell store, a seed
// step, then per queued frontier entry a queue read, a cell read and, per
// in-range neighbor, a select and read step then an evaluate and write back
// step, then the finish steps.
// i_in.ready is low for the whole run. The result sits in an output register;
// a new run only finishes once the previous result has been taken.
// ----------------------------------------------------------------------------
module downhill_grid_path_counter_core #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dgpc_in_if.sink                       i_in,
    dgpc_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dgpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dgpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dgpc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [$clog2(MAX_ROWS+1)-1:0]    w_rows;
    logic [$clog2(MAX_COLUMNS+1)-1:0] w_cols;
    dgpc_pkg::t_walk_status           w_status;

    // configuration registers
    dgpc_cfg #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rows  (w_rows),
        .o_cols  (w_cols)
    );

    // loader and walk sequencer
    dgpc_walk #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rows   (w_rows),
        .i_cols   (w_cols),
        .i_in     (i_in),
        .o_out    (o_out),
        .o_status (w_status)
    );

    // beats only enter while the walker is idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> w_status.idle)
        else $error("height beat accepted during a run");

    // a last cell starts the clearing pass
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_cell) |=> w_status.clearing)
        else $error("run did not start with a clearing pass");

    // a result appears only at the end of a run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> !$past(w_status.idle))
        else $error("result appeared without a run");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Grid loads of random and shaped height maps through the valid/ready
// channel; an internal path-count predictor scores every result beat.
// Grid size changes over APB between drained phases, with random idling
// on both channels except in the closing phase.
// ----------------------------------------------------------------------------
module testbench;

    localparam int GRID_MAX = 64 * 64;
    localparam int RING_MAX = 2 * GRID_MAX;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_SLOPE,
        SHAPE_FLAT,
        SHAPE_STAIR
    } t_shape;

    typedef struct {
        logic [31:0] path_count;
        logic        overflow;
    } t_path_result;

    // Scoreboard: grid model, path-count predictor and queue of expected beats
    class path_scoreboard;
        logic [15:0]  heights [GRID_MAX];
        bit           loaded [GRID_MAX];
        int unsigned  load_pos;
        int unsigned  rows;
        int unsigned  cols;
        int unsigned  lvl [GRID_MAX];
        logic [31:0]  cnt_now [GRID_MAX];
        logic [31:0]  cnt_old [GRID_MAX];
        int unsigned  ring [RING_MAX];
        bit           sat_seen;
        t_path_result pending_q[$];
        int           mismatches;
        int           results_seen;
        int           saturated_runs;

        function new();
            rows = 64;
            cols = 64;
            load_pos = 0;
            mismatches = 0;
            results_seen = 0;
            saturated_runs = 0;
            foreach (loaded[i]) loaded[i] = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned raw);
            int unsigned v;
            v = raw & 32'h7f;
            if (v == 0) return 1;
            if (v > 64) return 64;
            return v;
        endfunction

        function void set_dims(int unsigned raw_rows, int unsigned raw_cols);
            rows = clamp_dim(raw_rows);
            cols = clamp_dim(raw_cols);
        endfunction

        function bit grid_filled();
            for (int i = 0; i < rows * cols; i++)
                if (!loaded[i]) return 0;
            return 1;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s[32]) begin
                sat_seen = 1;
                return 32'hffff_ffff;
            end
            return s[31:0];
        endfunction

        // level-ordered frontier walk over the stored grid
        function logic [31:0] count_paths();
            int unsigned cells, hp, occ, batch, here, nb;
            int r, c, nr, nc;
            cells = rows * cols;
            hp = 0;
            occ = 1;
            sat_seen = 0;
            for (int i = 0; i < GRID_MAX; i++) begin
                lvl[i] = 0;
                cnt_now[i] = 0;
                cnt_old[i] = 0;
            end
            cnt_now[0] = 1;
            ring[0] = 0;
            while (occ > 0) begin
                batch = occ;
                for (int k = 0; k < batch; k++) begin
                    here = ring[hp] % cells;
                    r = here / cols;
                    c = here % cols;
                    for (int d = 0; d < 4; d++) begin
                        nr = r + ((d == dgpc_pkg::DIR_DOWN) ? 1 :
                                  (d == dgpc_pkg::DIR_UP) ? -1 : 0);
                        nc = c + ((d == dgpc_pkg::DIR_RIGHT) ? 1 :
                                  (d == dgpc_pkg::DIR_LEFT) ? -1 : 0);
                        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                        nb = nr * cols + nc;
                        if (heights[here] <= heights[nb]) continue;
                        if (lvl[nb] == lvl[here] + 1) begin
                            cnt_now[nb] = add_sat(cnt_now[nb], cnt_now[here]);
                        end else begin
                            cnt_old[nb] = add_sat(cnt_old[nb], cnt_now[nb]);
                            lvl[nb] = lvl[here] + 1;
                            cnt_now[nb] = cnt_now[here];
                            if (occ < RING_MAX) begin
                                ring[(hp + occ) % RING_MAX] = nb;
                                occ++;
                            end
                        end
                    end
                    hp = (hp + 1) % RING_MAX;
                    occ--;
                end
            end
            return add_sat(cnt_old[cells - 1], cnt_now[cells - 1]);
        endfunction

        // accepted height beat
        function void note_cell(logic [15:0] h, logic last);
            t_path_result res;
            if (load_pos < rows * cols) begin
                heights[load_pos] = h;
                loaded[load_pos] = 1;
                load_pos++;
            end
            if (last) begin
                res.path_count = count_paths();
                res.overflow = sat_seen;
                if (sat_seen) saturated_runs++;
                pending_q.push_back(res);
                load_pos = 0;
            end
        endfunction

        // accepted result beat
        function void check_result(logic [31:0] pc, logic ov);
            t_path_result want;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat count=%0d ovf=%0b", pc, ov);
                return;
            end
            want = pending_q.pop_front();
            if (pc !== want.path_count || ov !== want.overflow) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result mismatch exp count=%0d ovf=%0b got count=%0d ovf=%0b",
                             want.path_count, want.overflow, pc, ov);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [dgpc_pkg::PADDR_W-1:0] paddr;
    logic [dgpc_pkg::PDATA_W-1:0] pwdata;
    logic [dgpc_pkg::PDATA_W-1:0] prdata;
    logic        pready;

    dgpc_in_if  in_ch ();
    dgpc_out_if out_ch ();

    downhill_grid_path_counter_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    path_scoreboard sb;
    bit idle_on;
    int sink_hold;
    int cells_sent;
    int grids_run;

    always #10 i_clk = ~i_clk;

    // result-side stalls in random bursts
    always @(negedge i_clk) begin
        if (!idle_on) begin
            out_ch.ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(5) == 0) begin
            sink_hold = $urandom_range(9, 1) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // score every result beat
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.path_count, out_ch.overflow);
    end

    // run watchdog
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic apb_write(input logic idx, input int unsigned value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic end_beats();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // hold off until every expected result beat has been taken
    task automatic drain();
        end_beats();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_grid(input int unsigned raw_rows, input int unsigned raw_cols);
        drain();
        apb_write(dgpc_pkg::REG_ROW_COUNT, raw_rows);
        apb_write(dgpc_pkg::REG_COLUMN_COUNT, raw_cols);
        sb.set_dims(raw_rows, raw_cols);
    endtask

    task automatic send_cell(input logic [15:0] h, input logic last);
        @(negedge i_clk);
        if (idle_on && $urandom_range(3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.height    <= h;
        in_ch.last_cell <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_cell(h, last);
        cells_sent++;
    endtask

    // one grid load; beats may run short (if the store is filled) or long
    task automatic load_grid(input t_shape shape);
        int unsigned cells, n, r, c;
        logic [15:0] h;
        cells = sb.rows * sb.cols;
        n = cells;
        if ($urandom_range(9) == 0)
            n = cells + $urandom_range(3, 1);
        else if (cells > 1 && $urandom_range(9) == 0 && sb.grid_filled())
            n = $urandom_range(cells - 1, 1);
        for (int i = 0; i < n; i++) begin
            r = (i % cells) / sb.cols;
            c = (i % cells) % sb.cols;
            case (shape)
                SHAPE_RANDOM: h = 16'($urandom_range(16'hffff));
                SHAPE_SLOPE:  h = 16'(60000 - (r + c) * 100 + $urandom_range(250));
                SHAPE_FLAT:   h = 16'($urandom_range(3));
                default:      h = 16'(16'hffff - (r + c) * 1000);
            endcase
            send_cell(h, i == n - 1);
        end
        grids_run++;
    endtask

    initial begin
        int unsigned rr, cc;
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.height = '0;
        in_ch.last_cell = 1'b0;
        out_ch.ready = 1'b0;
        idle_on = 1'b1;
        sink_hold = 0;
        cells_sent = 0;
        grids_run = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single cell, two cells both ways, overrun, tiny diamond
        set_grid(0, 0);
        send_cell(16'hffff, 1'b1);
        send_cell(16'h0000, 1'b1);
        set_grid(1, 2);
        send_cell(16'd5, 1'b0);
        send_cell(16'd3, 1'b1);
        send_cell(16'd3, 1'b0);
        send_cell(16'd5, 1'b1);
        send_cell(16'd9, 1'b0);
        send_cell(16'd8, 1'b0);
        send_cell(16'd7, 1'b1);
        set_grid(2, 2);
        send_cell(16'd9, 1'b0);
        send_cell(16'd5, 1'b0);
        send_cell(16'd5, 1'b0);
        send_cell(16'd1, 1'b1);
        // early last cell: remaining cells come from the previous load
        send_cell(16'd7, 1'b1);
        end_beats();

        // random phases
        while (cells_sent < 950) begin
            if (cells_sent > 800) idle_on = 1'b0;
            case ($urandom_range(11))
                0: begin rr = 64; cc = $urandom_range(2, 1); end
                1: begin rr = $urandom_range(2, 1); cc = 127; end
                2: begin rr = $urandom_range(127, 65); cc = 1; end
                3: begin rr = 0; cc = $urandom_range(8, 1); end
                default: begin rr = $urandom_range(8, 1); cc = $urandom_range(8, 1); end
            endcase
            set_grid(rr, cc);
            repeat ($urandom_range(5, 2))
                if (cells_sent < 950) load_grid(t_shape'($urandom_range(3)));
            end_beats();
            if (sb.saturated_runs == 0 && cells_sent > 300) begin
                // large stair grid overflows the 32-bit count
                set_grid(19, 19);
                load_grid(SHAPE_STAIR);
                end_beats();
            end
        end

        drain();
        $display("Ran %0d grid loads (%0d height beats), %0d result beats, %0d saturated.",
                 grids_run, cells_sent, sb.results_seen, sb.saturated_runs);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
